### src/esc_pkg.sv
// Shared token codes, result codes, parser phases and the result record.
package esc_pkg;

  localparam int unsigned MaxNest = 255;
  localparam int unsigned DepthW  = $clog2(MaxNest + 1);

  localparam int unsigned KindW = 4;
  localparam int unsigned PosW  = 16;

  typedef enum logic [KindW-1:0] {
    KVar     = 4'd0,
    KIdent   = 4'd1,
    KNum     = 4'd2,
    KPlus    = 4'd3,
    KMinus   = 4'd4,
    KMult    = 4'd5,
    KEqual   = 4'd6,
    KLparen  = 4'd7,
    KRparen  = 4'd8,
    KNewline = 4'd9,
    KEof     = 4'd10,
    KInvalid = 4'd11
  } token_kind_e;

  typedef enum logic [1:0] {
    StContinue = 2'd0,
    StCorrect  = 2'd1,
    StError    = 2'd2,
    StHalted   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ErrNone       = 3'd0,
    ErrUnexpected = 3'd1,
    ErrOperand    = 3'd2,
    ErrEol        = 3'd3,
    ErrNest       = 3'd4
  } err_kind_e;

  typedef enum logic [5:0] {
    PhLineStart     = 6'b000001,
    PhAfterVar      = 6'b000010,
    PhWantEqual     = 6'b000100,
    PhWantOperand   = 6'b001000,
    PhAfterOperand  = 6'b010000,
    PhHalted        = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  line;
    logic [PosW-1:0]  column;
  } token_t;

  typedef struct packed {
    status_e          status;
    err_kind_e        err_kind;
    logic [KindW-1:0] expected;
    logic [PosW-1:0]  line;
    logic [PosW-1:0]  column;
  } result_t;

endpackage

### src/esc_in_stage.sv
// Input register that holds one token request until the parser takes it.
module esc_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  token_valid_i,
  output logic                  token_stall_o,
  input  esc_pkg::token_t       token_i,
  input  logic                  take_i,
  output logic                  valid_o,
  output esc_pkg::token_t       token_o
);
  import esc_pkg::*;

  logic   valid_q, valid_d;
  token_t token_q;
  logic   load;

  // The register can refill in the same cycle that its content moves on.
  assign token_stall_o = valid_q && !take_i;
  assign load          = token_valid_i && !token_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      token_q <= token_i;
    end
  end

  assign valid_o = valid_q;
  assign token_o = token_q;

endmodule

### src/esc_parse_core.sv
// Parser state machine and nesting counter; computes one result per token.
module esc_parse_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  esc_pkg::token_t token_i,
  output esc_pkg::result_t result_o
);
  import esc_pkg::*;

  phase_e            phase_q, phase_d;
  logic [DepthW-1:0] depth_q, depth_d;
  result_t           res;
  logic              operand;
  logic              is_op;

  always_comb begin
    phase_d = phase_q;
    depth_d = depth_q;
    operand = 1'b0;
    is_op   = (token_i.kind == KPlus) || (token_i.kind == KMinus) ||
              (token_i.kind == KMult);
    res          = '0;
    res.status   = StContinue;
    res.err_kind = ErrNone;

    unique case (phase_q)
      PhLineStart: begin
        if (token_i.kind == KNewline) begin
          phase_d = PhLineStart;
        end else if (token_i.kind == KEof) begin
          phase_d    = PhHalted;
          res.status = StCorrect;
        end else if (token_i.kind == KVar) begin
          phase_d = PhAfterVar;
        end else begin
          operand = 1'b1;
        end
      end
      PhAfterVar: begin
        if (token_i.kind == KIdent) begin
          phase_d = PhWantEqual;
        end else begin
          phase_d      = PhHalted;
          res.status   = StError;
          res.err_kind = ErrUnexpected;
          res.expected = KIdent;
          res.line     = token_i.line;
          res.column   = token_i.column;
        end
      end
      PhWantEqual: begin
        if (token_i.kind == KEqual) begin
          phase_d = PhWantOperand;
        end else begin
          phase_d      = PhHalted;
          res.status   = StError;
          res.err_kind = ErrUnexpected;
          res.expected = KEqual;
          res.line     = token_i.line;
          res.column   = token_i.column;
        end
      end
      PhWantOperand: begin
        operand = 1'b1;
      end
      PhAfterOperand: begin
        if (is_op) begin
          phase_d = PhWantOperand;
        end else if (depth_q != '0) begin
          // Inside parentheses only a closing one may end the operand.
          if (token_i.kind == KRparen) begin
            depth_d = depth_q - DepthW'(1);
          end else begin
            phase_d      = PhHalted;
            res.status   = StError;
            res.err_kind = ErrUnexpected;
            res.expected = KRparen;
            res.line     = token_i.line;
            res.column   = token_i.column;
          end
        end else if (token_i.kind == KNewline) begin
          phase_d = PhLineStart;
        end else if (token_i.kind == KEof) begin
          phase_d    = PhHalted;
          res.status = StCorrect;
        end else begin
          phase_d      = PhHalted;
          res.status   = StError;
          res.err_kind = ErrEol;
          res.line     = token_i.line;
          res.column   = token_i.column;
        end
      end
      default: begin
        phase_d    = PhHalted;
        res.status = StHalted;
      end
    endcase

    // Start of a factor: a number, an identifier or an opening parenthesis.
    if (operand) begin
      if ((token_i.kind == KNum) || (token_i.kind == KIdent)) begin
        phase_d = PhAfterOperand;
      end else if (token_i.kind == KLparen) begin
        if (depth_q == DepthW'(MaxNest)) begin
          phase_d      = PhHalted;
          res.status   = StError;
          res.err_kind = ErrNest;
          res.line     = token_i.line;
          res.column   = token_i.column;
        end else begin
          depth_d = depth_q + DepthW'(1);
          phase_d = PhWantOperand;
        end
      end else begin
        phase_d      = PhHalted;
        res.status   = StError;
        res.err_kind = ErrOperand;
        res.line     = token_i.line;
        res.column   = token_i.column;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLineStart;
      depth_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      depth_q <= depth_d;
    end
  end

  assign result_o = res;

endmodule

### src/expression_syntax_checker.sv
// Top level of the token stream syntax checker.
//
//   channel  direction  handshake                     payload
//   token    in         token_valid_i / token_stall_o  token_kind_i, token_line_i,
//                                                      token_column_i
//   result   out        result_valid_o / result_stall_i status_o, error_kind_o,
//                                                      expected_kind_o, error_line_o,
//                                                      error_column_o
//
// One token per cycle is taken unless a stalled result backs up the input register.
// The token sits in an input register, the parser evaluates it and the result
// lands in an output register, so a new request is accepted while a result waits.
// Reset clears the parser to the start of a line with no open parentheses.
// A stalled result holds the output register and then backs up the input register.
module expression_syntax_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        token_valid_i,
  output logic                        token_stall_o,
  input  logic [esc_pkg::KindW-1:0]   token_kind_i,
  input  logic [esc_pkg::PosW-1:0]    token_line_i,
  input  logic [esc_pkg::PosW-1:0]    token_column_i,
  output logic                        result_valid_o,
  input  logic                        result_stall_i,
  output logic [1:0]                  status_o,
  output logic [2:0]                  error_kind_o,
  output logic [esc_pkg::KindW-1:0]   expected_kind_o,
  output logic [esc_pkg::PosW-1:0]    error_line_o,
  output logic [esc_pkg::PosW-1:0]    error_column_o
);
  import esc_pkg::*;

  token_t  tok_in, tok_held;
  logic    held_valid;
  logic    out_ready;
  logic    step;
  result_t res;
  result_t res_q;
  logic    out_valid_q, out_valid_d;

  assign tok_in.kind   = token_kind_i;
  assign tok_in.line   = token_line_i;
  assign tok_in.column = token_column_i;

  assign out_ready = !out_valid_q || !result_stall_i;
  assign step      = held_valid && out_ready;

  esc_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .token_valid_i (token_valid_i),
    .token_stall_o (token_stall_o),
    .token_i       (tok_in),
    .take_i        (out_ready),
    .valid_o       (held_valid),
    .token_o       (tok_held)
  );

  esc_parse_core u_parse_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .token_i  (tok_held),
    .result_o (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = held_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign status_o        = res_q.status;
  assign error_kind_o    = res_q.err_kind;
  assign expected_kind_o = res_q.expected;
  assign error_line_o    = res_q.line;
  assign error_column_o  = res_q.column;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the token stream syntax checker.
`timescale 1ns / 100ps

module tb_top;
  import esc_pkg::*;

  localparam int BodyTokens  = 1350;
  localparam int DeepAfter   = 200;
  localparam int TailTokens  = 24;
  localparam int HoldCycles  = 300;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 20;

  typedef struct packed {
    phase_e            phase;
    logic [DepthW-1:0] depth;
  } parser_state_t;

  // Tracks the parser state and keeps the results still owed by the block.
  class parse_scoreboard;
    result_t       owed_q[$];
    parser_state_t st;
    int            mismatches;

    function new();
      st.phase   = PhLineStart;
      st.depth   = '0;
      mismatches = 0;
    endfunction

    static function result_t plain_result(status_e s);
      result_t r;
      r = '0;
      r.status = s;
      return r;
    endfunction

    static function result_t syntax_error(inout parser_state_t ps, input err_kind_e ek,
                                          input logic [KindW-1:0] want,
                                          input token_t tok);
      result_t r;
      ps.phase   = PhHalted;
      r.status   = StError;
      r.err_kind = ek;
      r.expected = want;
      r.line     = tok.line;
      r.column   = tok.column;
      return r;
    endfunction

    // A factor is a number, an identifier or an opening parenthesis.
    static function result_t start_factor(inout parser_state_t ps, input token_t tok);
      if (tok.kind == KNum || tok.kind == KIdent) begin
        ps.phase = PhAfterOperand;
        return plain_result(StContinue);
      end
      if (tok.kind == KLparen) begin
        if (ps.depth >= MaxNest) return syntax_error(ps, ErrNest, '0, tok);
        ps.depth = ps.depth + 1'b1;
        ps.phase = PhWantOperand;
        return plain_result(StContinue);
      end
      return syntax_error(ps, ErrOperand, '0, tok);
    endfunction

    static function result_t parse_step(inout parser_state_t ps, input token_t tok);
      result_t r;
      case (ps.phase)
        PhLineStart: begin
          if (tok.kind == KNewline) begin
            r = plain_result(StContinue);
          end else if (tok.kind == KEof) begin
            ps.phase = PhHalted;
            r = plain_result(StCorrect);
          end else if (tok.kind == KVar) begin
            ps.phase = PhAfterVar;
            r = plain_result(StContinue);
          end else begin
            r = start_factor(ps, tok);
          end
        end
        PhAfterVar: begin
          if (tok.kind != KIdent) begin
            r = syntax_error(ps, ErrUnexpected, KIdent, tok);
          end else begin
            ps.phase = PhWantEqual;
            r = plain_result(StContinue);
          end
        end
        PhWantEqual: begin
          if (tok.kind != KEqual) begin
            r = syntax_error(ps, ErrUnexpected, KEqual, tok);
          end else begin
            ps.phase = PhWantOperand;
            r = plain_result(StContinue);
          end
        end
        PhWantOperand: r = start_factor(ps, tok);
        PhAfterOperand: begin
          if (tok.kind == KPlus || tok.kind == KMinus || tok.kind == KMult) begin
            ps.phase = PhWantOperand;
            r = plain_result(StContinue);
          end else if (ps.depth != 0) begin
            if (tok.kind != KRparen) begin
              r = syntax_error(ps, ErrUnexpected, KRparen, tok);
            end else begin
              ps.depth = ps.depth - 1'b1;
              r = plain_result(StContinue);
            end
          end else if (tok.kind == KNewline) begin
            ps.phase = PhLineStart;
            r = plain_result(StContinue);
          end else if (tok.kind == KEof) begin
            ps.phase = PhHalted;
            r = plain_result(StCorrect);
          end else begin
            r = syntax_error(ps, ErrEol, '0, tok);
          end
        end
        default: begin
          ps.phase = PhHalted;
          r = plain_result(StHalted);
        end
      endcase
      return r;
    endfunction

    function void note_token(token_t tok);
      owed_q.push_back(parse_step(st, tok));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing owed: st=%0d ek=%0d xk=%0d ln=%0d col=%0d",
                   got.status, got.err_kind, got.expected, got.line, got.column);
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status || got.err_kind !== want.err_kind ||
          got.expected !== want.expected || got.line !== want.line ||
          got.column !== want.column) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("result mismatch: want st=%0d ek=%0d xk=%0d ln=%0d col=%0d,",
                 want.status, want.err_kind, want.expected, want.line, want.column);
          $display(" got st=%0d ek=%0d xk=%0d ln=%0d col=%0d",
                   got.status, got.err_kind, got.expected, got.line, got.column);
        end
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                tok_valid = 1'b0;
  logic                tok_stall;
  logic [KindW-1:0]    tok_kind  = '0;
  logic [PosW-1:0]     tok_line  = '0;
  logic [PosW-1:0]     tok_col   = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic [1:0]          res_status;
  logic [2:0]          res_err_kind;
  logic [KindW-1:0]    res_expected;
  logic [PosW-1:0]     res_line;
  logic [PosW-1:0]     res_col;

  parse_scoreboard sb;
  parser_state_t   gen_st;
  int              target_depth;
  int              burst_left;

  // A short program touching every token that can appear in a correct line.
  token_kind_e opening [24] = '{KVar, KIdent, KEqual, KLparen, KNum, KPlus, KIdent,
                                KRparen, KMult, KNum, KMinus, KLparen, KIdent, KRparen,
                                KNewline, KNewline, KLparen, KLparen, KNum, KRparen,
                                KRparen, KMinus, KIdent, KNewline};
  logic [PosW-1:0] pos_pattern [4] = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};

  expression_syntax_checker u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .token_valid_i  (tok_valid),
    .token_stall_o  (tok_stall),
    .token_kind_i   (tok_kind),
    .token_line_i   (tok_line),
    .token_column_i (tok_col),
    .result_valid_o (res_valid),
    .result_stall_i (res_stall),
    .status_o       (res_status),
    .error_kind_o   (res_err_kind),
    .expected_kind_o(res_expected),
    .error_line_o   (res_line),
    .error_column_o (res_col)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [KindW-1:0] pick_factor();
    if (gen_st.depth < target_depth) return KLparen;
    case ($urandom_range(0, 5))
      0, 1: return KNum;
      2, 3, 4: return KIdent;
      default: return (gen_st.depth < 8) ? KLparen : KNum;
    endcase
  endfunction

  function automatic logic [KindW-1:0] pick_operator();
    case ($urandom_range(0, 2))
      0: return KPlus;
      1: return KMinus;
      default: return KMult;
    endcase
  endfunction

  // Chooses a token that keeps the program well formed, steering toward target_depth.
  function automatic logic [KindW-1:0] pick_well_formed();
    case (gen_st.phase)
      PhLineStart: begin
        case ($urandom_range(0, 7))
          0: return KNewline;
          1, 2: return KVar;
          default: return pick_factor();
        endcase
      end
      PhAfterVar: return KIdent;
      PhWantEqual: return KEqual;
      PhWantOperand: return pick_factor();
      default: begin
        if (target_depth != 0 && gen_st.depth >= target_depth) target_depth = 0;
        if (gen_st.depth < target_depth) return pick_operator();
        if (gen_st.depth != 0) return ($urandom_range(0, 3) == 0) ? pick_operator() : KRparen;
        return ($urandom_range(0, 1) == 0) ? pick_operator() : KNewline;
      end
    endcase
  endfunction

  task automatic send_token(input logic [KindW-1:0] kind, input logic [PosW-1:0] ln,
                            input logic [PosW-1:0] col);
    token_t tok;
    tok.kind   = kind;
    tok.line   = ln;
    tok.column = col;
    if (burst_left == 0) begin
      tok_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    burst_left--;
    tok_valid <= 1'b1;
    tok_kind  <= kind;
    tok_line  <= ln;
    tok_col   <= col;
    @(posedge clk);
    while (tok_stall) @(posedge clk);
    sb.note_token(tok);
    void'(parse_scoreboard::parse_step(gen_st, tok));
  endtask

  task automatic send_well_formed();
    send_token(pick_well_formed(), PosW'($urandom_range(0, 65535)),
               PosW'($urandom_range(0, 65535)));
  endtask

  task automatic send_any(input logic [KindW-1:0] kind);
    send_token(kind, PosW'($urandom_range(0, 65535)), PosW'($urandom_range(0, 65535)));
  endtask

  initial begin : stimulus
    int   ending;
    bit   dove;
    logic [KindW-1:0] bad;
    sb           = new();
    gen_st.phase = PhLineStart;
    gen_st.depth = '0;
    target_depth = 0;
    burst_left   = 0;
    dove         = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);

    foreach (opening[i])
      send_token(opening[i], pos_pattern[i % 4], pos_pattern[(i + 1) % 4]);

    for (int n = 0; n < BodyTokens; n++) begin
      if (gen_st.phase == PhLineStart) begin
        if (!dove && n >= DeepAfter) begin
          // One line nests all the way to the limit and back.
          target_depth = MaxNest;
          dove = 1'b1;
        end else if (target_depth != MaxNest) begin
          target_depth = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
        end
      end
      send_well_formed();
    end

    // The program ends in exactly one way, since only reset leaves the halted phase.
    ending = $urandom_range(0, 5);
    case (ending)
      0: begin
        target_depth = 0;
        while (gen_st.phase != PhLineStart) send_well_formed();
        send_any(KEof);
      end
      1: begin
        target_depth = 0;
        while (!(gen_st.phase == PhAfterOperand && gen_st.depth == 0)) send_well_formed();
        send_any(KEof);
      end
      2: begin
        target_depth = MaxNest;
        while (!(gen_st.phase == PhWantOperand && gen_st.depth == MaxNest))
          send_well_formed();
        send_any(KLparen);
      end
      3: begin
        target_depth = 0;
        while (!(gen_st.phase == PhAfterOperand && gen_st.depth == 0)) send_well_formed();
        send_any(KRparen);
      end
      4: begin
        target_depth = $urandom_range(1, 4);
        while (!(gen_st.phase == PhAfterOperand && gen_st.depth != 0)) send_well_formed();
        do begin
          bad = KindW'($urandom_range(0, 15));
        end while (bad == KPlus || bad == KMinus || bad == KMult || bad == KRparen);
        send_any(bad);
      end
      default: begin
        do begin
          send_any(($urandom_range(0, 1) == 0) ? KindW'($urandom_range(11, 15))
                                               : KindW'($urandom_range(0, 15)));
        end while (gen_st.phase != PhHalted);
      end
    endcase

    repeat (TailTokens) send_any(KindW'($urandom_range(0, 15)));
    tok_valid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : receiver
    int mode;
    wait (rst_n === 1'b1);
    repeat (150) begin
      @(posedge clk);
      res_stall <= ($urandom_range(0, 2) == 0);
    end
    // Long hold so the result register fills and the token request backs up.
    repeat (HoldCycles) begin
      @(posedge clk);
      res_stall <= 1'b1;
    end
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 120)) begin
        @(posedge clk);
        case (mode)
          0: res_stall <= 1'b0;
          1: res_stall <= ($urandom_range(0, 3) == 0);
          2: res_stall <= ($urandom_range(0, 3) != 0);
          default: res_stall <= ~res_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t seen;
    if (res_valid === 1'b1 && res_stall == 1'b0) begin
      seen.status   = status_e'(res_status);
      seen.err_kind = err_kind_e'(res_err_kind);
      seen.expected = res_expected;
      seen.line     = res_line;
      seen.column   = res_col;
      sb.check_result(seen);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk);
      if ((tok_valid && tok_stall === 1'b0) || (res_valid === 1'b1 && !res_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
